@@ hdl/cfr_pkg.sv @@
// Shared constants, types and helper functions for the calibration frame receiver.
package cfr_pkg;

   typedef logic [6:0]  addr_type;
   typedef logic [15:0] crc_type;

   localparam int unsigned FRAME_BYTES = 68;
   localparam addr_type    LAST_ADDR   = 7'(FRAME_BYTES - 1);
   localparam addr_type    SCAN_FIRST  = 7'd2;
   localparam logic [7:0]  SYNC_A      = 8'd117;
   localparam logic [7:0]  SYNC_B      = 8'd84;
   localparam crc_type     CRC_POLY    = 16'hA001;
   localparam crc_type     CRC_SEED    = 16'hFFFF;
   localparam logic [3:0]  LAST_SLOT   = 4'd12;

   // One byte of reflected CRC-16, LSB first.
   function automatic crc_type crc_byte(input crc_type c, input logic [7:0] b);
      crc_type r;
      r = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (r[0]) begin
            r = (r >> 1) ^ CRC_POLY;
         end else begin
            r = r >> 1;
         end
      end
      return r;
   endfunction

   // First frame byte of the payload word carried in a slot.
   function automatic addr_type word_base(input logic [3:0] slot);
      logic [3:0] w;
      case (slot)
         4'd0:    w = 4'd6;
         4'd1:    w = 4'd7;
         4'd2:    w = 4'd8;
         4'd3:    w = 4'd9;
         4'd4:    w = 4'd10;
         4'd5:    w = 4'd13;
         4'd6:    w = 4'd14;
         4'd7:    w = 4'd13;
         4'd8:    w = 4'd11;
         4'd9:    w = 4'd15;
         4'd10:   w = 4'd14;
         4'd11:   w = 4'd15;
         default: w = 4'd12;
      endcase
      return 7'd2 + {1'b0, w, 2'b00};
   endfunction

endpackage

@@ hdl/calibration_frame_receiver_core.sv @@
// Sync-word framed calibration record receiver with CRC-16 check and resync.
// A byte that does not complete a frame is taken while the core stays in receive.
// A completed frame runs a CRC pass (one byte per cycle through the shared
// buffer read port), then reads out 13 result words when the CRC is good, each
// held until taken, then a resync scan and, if a sync pair is found, a tail move.
// No new byte is taken until these passes end; all use the single buffer read port.
// Reset: synchronous; clears fill count, state and sensor index; buffer holds junk.
module calibration_frame_receiver_core
   import cfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] word_value
   output logic [6:0]  rsp_tuser,   // [2:0] record_sensor, [6:3] slot
   output logic        rsp_tlast,   // last_word
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_wr_data
);

   localparam logic [2:0] S_RECV     = 3'd0;
   localparam logic [2:0] S_CRC      = 3'd1;
   localparam logic [2:0] S_EMIT_RD  = 3'd2;
   localparam logic [2:0] S_EMIT_OUT = 3'd3;
   localparam logic [2:0] S_SCAN     = 3'd4;
   localparam logic [2:0] S_MOVE     = 3'd5;

   logic [7:0]  mem [FRAME_BYTES];

   logic [2:0]  state_ff, state_in;
   addr_type    fill_ff, fill_in;
   logic [2:0]  sensor_ff;
   logic        lag_ff, lag_in;
   addr_type    rd_addr_ff, rd_addr_in;
   addr_type    dad_ff;
   logic [7:0]  rd_data_ff;
   crc_type     crc_ff, crc_in, crc_next;
   logic [3:0]  slot_ff, slot_in;
   logic [1:0]  bc_ff, bc_in;
   logic [31:0] word_ff, word_in;
   logic [7:0]  prev_ff, prev_in;
   addr_type    wr_ptr_ff, wr_ptr_in;
   logic [2:0]  rec_ff, rec_in;
   logic        mem_we;
   addr_type    mem_wa;
   logic [7:0]  mem_wd;
   logic        req_beat;

   assign req_tready = (state_ff == S_RECV);
   assign rsp_tvalid = (state_ff == S_EMIT_OUT);
   assign rsp_tdata  = word_ff;
   assign rsp_tuser  = {slot_ff, rec_ff};
   assign rsp_tlast  = (slot_ff == LAST_SLOT);
   assign req_beat   = req_tvalid && req_tready;
   assign crc_next   = crc_byte(crc_ff, rd_data_ff);

   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      rd_addr_in = (rd_addr_ff == LAST_ADDR) ? rd_addr_ff : rd_addr_ff + 7'd1;
      lag_in     = 1'b1;
      crc_in     = crc_ff;
      slot_in    = slot_ff;
      bc_in      = bc_ff;
      word_in    = word_ff;
      prev_in    = prev_ff;
      wr_ptr_in  = wr_ptr_ff;
      rec_in     = rec_ff;
      mem_we     = 1'b0;
      mem_wa     = wr_ptr_ff;
      mem_wd     = rd_data_ff;
      unique case (state_ff)
         S_RECV: begin
            lag_in     = 1'b0;
            rd_addr_in = '0;
            if (req_beat) begin
               if (fill_ff == 7'd0 && req_tdata != SYNC_A) begin
                  fill_in = fill_ff;
               end else if (fill_ff == 7'd1 && req_tdata != SYNC_B) begin
                  fill_in = '0;
               end else begin
                  mem_we  = 1'b1;
                  mem_wa  = fill_ff;
                  mem_wd  = req_tdata;
                  fill_in = fill_ff + 7'd1;
                  if (fill_ff == LAST_ADDR) begin
                     state_in = S_CRC;
                     crc_in   = CRC_SEED;
                     rec_in   = sensor_ff;
                  end
               end
            end
         end
         S_CRC: begin
            if (lag_ff) begin
               crc_in = crc_next;
               if (dad_ff == LAST_ADDR) begin
                  lag_in = 1'b0;
                  if (crc_next == 16'h0000) begin
                     state_in   = S_EMIT_RD;
                     slot_in    = '0;
                     bc_in      = '0;
                     rd_addr_in = word_base(4'd0);
                  end else begin
                     state_in   = S_SCAN;
                     rd_addr_in = SCAN_FIRST;
                  end
               end
            end
         end
         S_EMIT_RD: begin
            if (lag_ff) begin
               word_in[{bc_ff, 3'b000} +: 8] = rd_data_ff;
               bc_in = bc_ff + 2'd1;
               if (bc_ff == 2'd3) begin
                  state_in = S_EMIT_OUT;
               end
            end
         end
         S_EMIT_OUT: begin
            rd_addr_in = rd_addr_ff;
            lag_in     = 1'b0;
            if (rsp_tready) begin
               if (slot_ff == LAST_SLOT) begin
                  state_in   = S_SCAN;
                  rd_addr_in = SCAN_FIRST;
               end else begin
                  state_in   = S_EMIT_RD;
                  slot_in    = slot_ff + 4'd1;
                  bc_in      = '0;
                  rd_addr_in = word_base(slot_ff + 4'd1);
               end
            end
         end
         S_SCAN: begin
            if (lag_ff) begin
               prev_in = rd_data_ff;
               // Pair found: start the tail move at the 117.
               if (dad_ff != SCAN_FIRST && prev_ff == SYNC_A && rd_data_ff == SYNC_B) begin
                  state_in   = S_MOVE;
                  rd_addr_in = dad_ff - 7'd1;
                  wr_ptr_in  = '0;
                  lag_in     = 1'b0;
               end else if (dad_ff == LAST_ADDR) begin
                  // Byte 0 already holds 117, so a trailing 117 needs no write.
                  fill_in  = (rd_data_ff == SYNC_A) ? 7'd1 : 7'd0;
                  state_in = S_RECV;
               end
            end
         end
         S_MOVE: begin
            if (lag_ff) begin
               mem_we    = 1'b1;
               mem_wa    = wr_ptr_ff;
               mem_wd    = rd_data_ff;
               wr_ptr_in = wr_ptr_ff + 7'd1;
               if (dad_ff == LAST_ADDR) begin
                  fill_in  = wr_ptr_ff + 7'd1;
                  state_in = S_RECV;
               end
            end
         end
         default: begin
            state_in = S_RECV;
            fill_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_RECV;
         fill_ff   <= '0;
         sensor_ff <= '0;
         lag_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         lag_ff   <= lag_in;
         if (csr_wr_en) begin
            sensor_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff <= rd_addr_in;
      dad_ff     <= rd_addr_ff;
      crc_ff     <= crc_in;
      slot_ff    <= slot_in;
      bc_ff      <= bc_in;
      word_ff    <= word_in;
      prev_ff    <= prev_in;
      wr_ptr_ff  <= wr_ptr_in;
      rec_ff     <= rec_in;
   end

   // Frame buffer: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[rd_addr_ff];
   end

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> fill_ff < 7'(FRAME_BYTES))
      else $error("fill count out of range while receiving");

   a_frame_done: assert property (@(posedge clock) disable iff (reset)
      (req_beat && fill_ff == LAST_ADDR) |=> state_ff == S_CRC)
      else $error("full frame did not start the CRC pass");

   a_next_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> state_ff == S_EMIT_RD)
      else $error("result beat did not advance to the next word");

   a_last_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> state_ff == S_SCAN)
      else $error("end of record did not start the resync scan");

   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_RECV) |-> rd_addr_ff <= LAST_ADDR)
      else $error("buffer read address beyond frame");

endmodule

@@ tb/calibration_frame_receiver_core_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the calibration frame receiver core.
module calibration_frame_receiver_core_tb;
   import cfr_pkg::*;

   localparam int RESET_CYCLES     = 12;
   localparam int SETTLE_CYCLES    = 320;
   localparam int LONG_HOLD_CYCLES = 700;
   localparam int CYCLE_LIMIT      = 600000;
   localparam int WORDS_PER_RECORD = 13;

   typedef struct packed {
      logic [2:0]  sensor;
      logic [3:0]  slot;
      logic [31:0] value;
      logic        last;
   } record_word_t;

   typedef enum logic [2:0] {
      ROW_NOISE,
      ROW_SYNC_MISS,
      ROW_FILL,
      ROW_BAD_CRC,
      ROW_RANDOM,
      ROW_EMBED,
      ROW_TRAIL
   } row_kind_e;

   typedef struct packed {
      row_kind_e   kind;
      logic [7:0]  fill;
      logic [6:0]  arg;
      logic        typed;
      logic [3:0]  typed_words;
      logic [31:0] typed_value;
   } directed_row_t;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic [6:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_wr_en;
   logic [2:0]  csr_wr_data;

   // receiver model state
   logic [7:0]   rx_buf [0:FRAME_BYTES-1];
   int           rx_fill;
   logic [2:0]   sensor_sel;
   bit           publish_words;
   record_word_t pending_words [$];

   logic [7:0]   frame_img [0:FRAME_BYTES-1];
   directed_row_t plan [0:13];

   int mismatches     = 0;
   int bytes_kept     = 0;
   int words_expected = 0;
   int words_checked  = 0;
   int frames_good    = 0;
   int frames_bad     = 0;
   int long_holds     = 0;
   bit steady         = 1'b0;
   bit hold_pending   = 1'b0;

   calibration_frame_receiver_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   function automatic logic [15:0] crc_fold(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

   // payload word index carried by each output slot
   function automatic int slot_word(input int s);
      case (s)
         0: return 6;
         1: return 7;
         2: return 8;
         3: return 9;
         4: return 10;
         5: return 13;
         6: return 14;
         7: return 13;
         8: return 11;
         9: return 15;
         10: return 14;
         11: return 15;
         default: return 12;
      endcase
   endfunction

   function automatic logic [7:0] any_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic expect_word(input record_word_t w);
      pending_words.push_back(w);
      words_expected++;
   endtask

   task automatic absorb_byte(input logic [7:0] b);
      logic [15:0]  c;
      record_word_t w;
      int           hit;
      int           base;
      if (rx_fill == 0 && b != SYNC_A) begin
         // still hunting: drop
      end else if (rx_fill == 1 && b != SYNC_B) begin
         rx_fill = 0;
      end else begin
         rx_buf[rx_fill] = b;
         rx_fill++;
         bytes_kept++;
         if (rx_fill == FRAME_BYTES) begin
            c = CRC_SEED;
            for (int k = 0; k < FRAME_BYTES; k++) c = crc_fold(c, rx_buf[k]);
            if (c == 16'h0000) begin
               frames_good++;
               for (int s = 0; s < WORDS_PER_RECORD; s++) begin
                  base    = 2 + 4 * slot_word(s);
                  w.sensor = sensor_sel;
                  w.slot   = 4'(s);
                  w.value  = {rx_buf[base+3], rx_buf[base+2], rx_buf[base+1], rx_buf[base]};
                  w.last   = (4'(s) == LAST_SLOT);
                  if (publish_words) expect_word(w);
               end
            end else begin
               frames_bad++;
            end
            // resync on the first sync pair past the header, else keep a trailing sync byte
            hit = 0;
            for (int p = 2; p < FRAME_BYTES - 1; p++) begin
               if (hit == 0 && rx_buf[p] == SYNC_A && rx_buf[p+1] == SYNC_B) hit = p;
            end
            if (hit != 0) begin
               for (int k = 0; k < FRAME_BYTES - hit; k++) rx_buf[k] = rx_buf[k+hit];
               rx_fill = FRAME_BYTES - hit;
            end else if (rx_buf[FRAME_BYTES-1] == SYNC_A) begin
               rx_buf[0] = SYNC_A;
               rx_fill   = 1;
            end else begin
               rx_fill = 0;
            end
         end
      end
   endtask

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = 0;
      if (!steady) begin
         if ($urandom_range(0, 15) == 0) gap = $urandom_range(8, 40);
         else if ($urandom_range(0, 2) == 0) gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      absorb_byte(b);
   endtask

   // Build a well-formed frame with a valid CRC in frame_img.
   function automatic void build_record(input bit random_fill, input logic [7:0] fill,
                                        input int plant);
      logic [15:0] c;
      frame_img[0] = SYNC_A;
      frame_img[1] = SYNC_B;
      for (int i = 2; i < FRAME_BYTES - 2; i++) frame_img[i] = random_fill ? any_byte() : fill;
      if (plant >= 2) begin
         frame_img[plant]   = SYNC_A;
         frame_img[plant+1] = SYNC_B;
      end
      c = CRC_SEED;
      for (int i = 0; i < FRAME_BYTES - 2; i++) c = crc_fold(c, frame_img[i]);
      frame_img[FRAME_BYTES-2] = c[7:0];
      frame_img[FRAME_BYTES-1] = c[15:8];
   endfunction

   task automatic send_record(input int first);
      for (int i = first; i < FRAME_BYTES; i++) send_byte(frame_img[i]);
   endtask

   // Outer frame whose tail at position p is the start of a good frame.
   task automatic send_embedded(input int p);
      send_byte(SYNC_A);
      send_byte(SYNC_B);
      repeat (p - 2) send_byte(any_byte());
      build_record(1'b1, 8'h00, 0);
      send_record(0);
   endtask

   // Frame with no sync pair inside that ends in a sync byte, then the rest of a good frame.
   task automatic send_trailing();
      send_byte(SYNC_A);
      send_byte(SYNC_B);
      repeat (FRAME_BYTES - 3) send_byte(8'($urandom_range(0, 116)));
      send_byte(SYNC_A);
      build_record(1'b1, 8'h00, 0);
      send_record(1);
   endtask

   task automatic drain();
      if (pending_words.size() != 0) begin
         req_tvalid <= 1'b0;
         while (pending_words.size() != 0) @(posedge clock);
      end
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_sensor(input logic [2:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      sensor_sel = v;
   endtask

   task automatic run_row(input directed_row_t row);
      bit use_typed;
      // typed values only hold when the row starts from an empty buffer
      use_typed     = row.typed && rx_fill == 0;
      publish_words = !use_typed;
      case (row.kind)
         ROW_NOISE: begin
            send_byte(8'h00);
            send_byte(8'hFF);
            send_byte(SYNC_B);
            send_byte(8'h74);
            send_byte(8'h76);
         end
         ROW_SYNC_MISS: begin
            send_byte(SYNC_A);
            send_byte(row.fill);
         end
         ROW_FILL: begin
            build_record(1'b0, row.fill, 0);
            send_record(0);
         end
         ROW_BAD_CRC: begin
            build_record(1'b0, row.fill, 0);
            frame_img[FRAME_BYTES-2][row.arg[2:0]] = ~frame_img[FRAME_BYTES-2][row.arg[2:0]];
            send_record(0);
         end
         ROW_RANDOM: begin
            build_record(1'b1, 8'h00, row.arg);
            send_record(0);
         end
         ROW_EMBED: send_embedded(row.arg);
         default:   send_trailing();
      endcase
      publish_words = 1'b1;
      if (use_typed) begin
         for (int s = 0; s < row.typed_words; s++) begin
            expect_word('{sensor_sel, 4'(s), row.typed_value, 4'(s) == LAST_SLOT});
         end
      end
   endtask

   task automatic run_random(input int min_bytes, input int min_words);
      int bytes_start;
      int words_start;
      int pick;
      bytes_start = bytes_kept;
      words_start = words_expected;
      while (bytes_kept - bytes_start < min_bytes || words_expected - words_start < min_words)
      begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            build_record(1'b1, 8'h00, ($urandom_range(0, 3) == 0) ? $urandom_range(2, 64) : 0);
            send_record(0);
         end else if (pick < 65) begin
            send_embedded($urandom_range(2, 66));
         end else if (pick < 73) begin
            send_trailing();
         end else if (pick < 81) begin
            build_record(1'b1, 8'h00, 0);
            pick = $urandom_range(2, FRAME_BYTES - 1);
            frame_img[pick] = frame_img[pick] ^ (8'h01 << $urandom_range(0, 7));
            send_record(0);
         end else if (pick < 90) begin
            repeat ($urandom_range(1, 6)) begin
               send_byte(($urandom_range(0, 3) == 0) ? SYNC_A : any_byte());
            end
         end else begin
            // abandoned frame: header and a few bytes, then whatever follows
            send_byte(SYNC_A);
            send_byte(SYNC_B);
            repeat ($urandom_range(0, 20)) send_byte(any_byte());
         end
         if ($urandom_range(0, 11) == 0) drain();
      end
   endtask

   // result side: random back-pressure plus one long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (hold_pending && rsp_tvalid) begin
            hold_pending = 1'b0;
            long_holds++;
            stall_left = LONG_HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else if (!steady && $urandom_range(0, 3) == 0) begin
            stall_left = (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(1, 3)) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      record_word_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_words.size() == 0) begin
            $error("result beat with nothing expected: word_value %h", rsp_tdata);
            mismatches++;
         end else begin
            want = pending_words.pop_front();
            words_checked++;
            if (rsp_tuser[2:0] !== want.sensor) begin
               $error("record_sensor: expected %0d, got %0d", want.sensor, rsp_tuser[2:0]);
               mismatches++;
            end
            if (rsp_tuser[6:3] !== want.slot) begin
               $error("slot: expected %0d, got %0d", want.slot, rsp_tuser[6:3]);
               mismatches++;
            end
            if (rsp_tdata !== want.value) begin
               $error("word_value: expected %h, got %h", want.value, rsp_tdata);
               mismatches++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_word: expected %0d, got %0d", want.last, rsp_tlast);
               mismatches++;
            end
         end
      end
   end

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles, %0d words still outstanding",
               cycles, pending_words.size());
      $display("calibration_frame_receiver_core verification failed");
      $finish;
   end

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = 8'h00;
      csr_wr_en     = 1'b0;
      csr_wr_data   = 3'd0;
      rx_fill       = 0;
      sensor_sel    = 3'd0;
      publish_words = 1'b1;

      plan[0]  = '{ROW_NOISE,     8'h00,  7'd0,  1'b1, 4'd0,  32'h0000_0000};
      plan[1]  = '{ROW_SYNC_MISS, 8'h00,  7'd0,  1'b1, 4'd0,  32'h0000_0000};
      plan[2]  = '{ROW_SYNC_MISS, SYNC_A, 7'd0,  1'b1, 4'd0,  32'h0000_0000};
      plan[3]  = '{ROW_FILL,      8'h00,  7'd0,  1'b1, 4'd13, 32'h0000_0000};
      plan[4]  = '{ROW_FILL,      8'hFF,  7'd0,  1'b1, 4'd13, 32'hFFFF_FFFF};
      plan[5]  = '{ROW_FILL,      8'hA5,  7'd0,  1'b1, 4'd13, 32'hA5A5_A5A5};
      plan[6]  = '{ROW_FILL,      SYNC_A, 7'd0,  1'b1, 4'd13, 32'h7575_7575};
      plan[7]  = '{ROW_BAD_CRC,   8'h5A,  7'd3,  1'b1, 4'd0,  32'h0000_0000};
      plan[8]  = '{ROW_RANDOM,    8'h00,  7'd0,  1'b0, 4'd0,  32'h0000_0000};
      plan[9]  = '{ROW_RANDOM,    8'h00,  7'd30, 1'b0, 4'd0,  32'h0000_0000};
      plan[10] = '{ROW_EMBED,     8'h00,  7'd2,  1'b0, 4'd0,  32'h0000_0000};
      plan[11] = '{ROW_EMBED,     8'h00,  7'd66, 1'b0, 4'd0,  32'h0000_0000};
      plan[12] = '{ROW_EMBED,     8'h00,  7'd35, 1'b0, 4'd0,  32'h0000_0000};
      plan[13] = '{ROW_TRAIL,     8'h00,  7'd0,  1'b0, 4'd0,  32'h0000_0000};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed rows run with the sensor tag at its reset value
      foreach (plan[i]) run_row(plan[i]);

      settle();
      write_sensor(3'd7);
      hold_pending = 1'b1;
      run_random(90, 39);

      settle();
      write_sensor(3'($urandom_range(1, 6)));
      steady = 1'b1;
      run_random(90, 39);

      settle();
      steady = 1'b0;
      write_sensor(3'd0);
      run_random(90, 39);

      settle();
      $display("run took %0d bytes into frames: %0d good and %0d rejected frames, %0d words checked",
               bytes_kept, frames_good, frames_bad, words_checked);
      $display("sensor tags 0, 7 and one between; %0d long output hold-off(s) with input backed up",
               long_holds);
      if (mismatches == 0) begin
         $display("calibration_frame_receiver_core verification clean");
      end else begin
         $display("calibration_frame_receiver_core verification failed");
      end
      $finish;
   end

endmodule

@@ calibration_frame_receiver_core.f @@
hdl/cfr_pkg.sv
hdl/calibration_frame_receiver_core.sv
tb/calibration_frame_receiver_core_tb.sv
